// ----- sv/itrt_pkg.sv -----
package itrt_pkg;

  localparam int unsigned NUM_W   = 32;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] BASE_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic [NUM_W-1:0]   mag;
    logic [RADIX_W-1:0] radix;
    logic               neg;
    logic               bad;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_e;

  localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;

  // floor(2^32 / b); quotient estimate is at most one low
  function automatic logic [NUM_W-1:0] recip(input logic [RADIX_W-1:0] b);
    logic [63:0] r;
    case (b)
      6'd2:    r = TWO_POW_32 / 2;
      6'd3:    r = TWO_POW_32 / 3;
      6'd4:    r = TWO_POW_32 / 4;
      6'd5:    r = TWO_POW_32 / 5;
      6'd6:    r = TWO_POW_32 / 6;
      6'd7:    r = TWO_POW_32 / 7;
      6'd8:    r = TWO_POW_32 / 8;
      6'd9:    r = TWO_POW_32 / 9;
      6'd10:   r = TWO_POW_32 / 10;
      6'd11:   r = TWO_POW_32 / 11;
      6'd12:   r = TWO_POW_32 / 12;
      6'd13:   r = TWO_POW_32 / 13;
      6'd14:   r = TWO_POW_32 / 14;
      6'd15:   r = TWO_POW_32 / 15;
      6'd16:   r = TWO_POW_32 / 16;
      6'd17:   r = TWO_POW_32 / 17;
      6'd18:   r = TWO_POW_32 / 18;
      6'd19:   r = TWO_POW_32 / 19;
      6'd20:   r = TWO_POW_32 / 20;
      6'd21:   r = TWO_POW_32 / 21;
      6'd22:   r = TWO_POW_32 / 22;
      6'd23:   r = TWO_POW_32 / 23;
      6'd24:   r = TWO_POW_32 / 24;
      6'd25:   r = TWO_POW_32 / 25;
      6'd26:   r = TWO_POW_32 / 26;
      6'd27:   r = TWO_POW_32 / 27;
      6'd28:   r = TWO_POW_32 / 28;
      6'd29:   r = TWO_POW_32 / 29;
      6'd30:   r = TWO_POW_32 / 30;
      6'd31:   r = TWO_POW_32 / 31;
      6'd32:   r = TWO_POW_32 / 32;
      6'd33:   r = TWO_POW_32 / 33;
      6'd34:   r = TWO_POW_32 / 34;
      6'd35:   r = TWO_POW_32 / 35;
      6'd36:   r = TWO_POW_32 / 36;
      default: r = 64'd0;
    endcase
    return r[NUM_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {2'b00, d};
    return (d < 6'd10) ? CHAR_ZERO + dx : CHAR_ALPHA + dx;
  endfunction

endpackage

// ----- sv/itrt_if.sv -----
interface itrt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] number;
  logic        [5:0]  radix;

  modport source (output valid, number, radix, input ready);
  modport sink   (input valid, number, radix, output ready);
endinterface

interface itrt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       bad_radix;

  modport source (output valid, out_char, last, bad_radix, input ready);
  modport sink   (input valid, out_char, last, bad_radix, output ready);
endinterface

// ----- sv/integer_to_radix_text.sv -----
// Flow: a job passes through the job queue, then the back end starts it and finds each digit
// by multiplying by the base's reciprocal, then correcting the remainder, then sends one
// transfer per character. The back end takes a new job only when idle, after the last
// character of the previous one; the queue holds waiting jobs. Characters go out one per
// cycle while out_o.ready is high; a bad base skips the divider and sends a lone nul.
// Reset: rst_ni is asynchronous, active low; it empties the queue and idles the divider.
module integer_to_radix_text #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itrt_in_if.sink    in_i,
  itrt_out_if.source out_o
);
  import itrt_pkg::*;

  job_t fr_job, bk_job;
  logic fr_valid, fr_ready, bk_valid, bk_ready;

  itrt_front u_front (
    .in_i        (in_i),
    .job_o       (fr_job),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready)
  );

  itrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_job)
  );

  itrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .job_i       (bk_job),
    .out_o       (out_o)
  );

endmodule

// ----- sv/itrt_front.sv -----
module itrt_front (
  itrt_in_if.sink         in_i,
  output itrt_pkg::job_t  job_o,
  output logic            job_valid_o,
  input  logic            job_ready_i
);
  import itrt_pkg::*;

  logic [NUM_W-1:0] raw;

  assign raw         = in_i.number;
  assign in_i.ready  = job_ready_i;
  assign job_valid_o = in_i.valid;

  always_comb begin
    job_o.radix = in_i.radix;
    job_o.bad   = (in_i.radix < BASE_MIN) || (in_i.radix > BASE_MAX);
    job_o.neg   = raw[NUM_W-1];
    job_o.mag   = raw[NUM_W-1] ? (~raw + 32'd1) : raw;
  end

endmodule

// ----- sv/itrt_queue.sv -----
module itrt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  itrt_pkg::job_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output itrt_pkg::job_t  pop_data_o
);
  import itrt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/itrt_back.sv -----
module itrt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  itrt_pkg::job_t  job_i,
  itrt_out_if.source      out_o
);
  import itrt_pkg::*;

  localparam int unsigned STACK_N = NUM_W;
  localparam int unsigned IDX_W   = $clog2(STACK_N);
  localparam int unsigned CNT_W   = $clog2(STACK_N + 1);

  back_state_e       state_q, state_d;
  logic [NUM_W-1:0]   mag_q, mag_d;
  logic [NUM_W-1:0]   prod_q, prod_d;
  logic [RADIX_W-1:0] base_q, base_d;
  logic               neg_q, neg_d;
  logic               bad_q, bad_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CHAR_W-1:0]  stack_q [STACK_N];

  logic               ov_q, ov_d;
  logic [CHAR_W-1:0]  oc_q, oc_d;
  logic               ol_q, ol_d;
  logic               ob_q, ob_d;

  logic [2*NUM_W-1:0] prod_full;
  logic [NUM_W-1:0]   base_x, r_raw, r_fix, q_fix;
  logic [IDX_W-1:0]   rd_idx;
  logic               load;

  assign job_ready_o     = (state_q == ST_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.out_char  = oc_q;
  assign out_o.last      = ol_q;
  assign out_o.bad_radix = ob_q;

  assign base_x    = {{(NUM_W-RADIX_W){1'b0}}, base_q};
  assign prod_full = {{NUM_W{1'b0}}, mag_q} * {{NUM_W{1'b0}}, recip(base_q)};
  assign r_raw     = mag_q - NUM_W'(prod_q * base_x);
  assign rd_idx    = IDX_W'(cnt_q - CNT_W'(1));
  assign load      = !ov_q || out_o.ready;

  always_comb begin
    if (r_raw >= base_x) begin
      r_fix = r_raw - base_x;
      q_fix = prod_q + NUM_W'(1);
    end else begin
      r_fix = r_raw;
      q_fix = prod_q;
    end
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    prod_d  = prod_q;
    base_d  = base_q;
    neg_d   = neg_q;
    bad_d   = bad_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_o.ready;
    oc_d    = oc_q;
    ol_d    = ol_q;
    ob_d    = ob_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          mag_d   = job_i.mag;
          base_d  = job_i.radix;
          neg_d   = job_i.neg;
          bad_d   = job_i.bad;
          cnt_d   = '0;
          state_d = job_i.bad ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = prod_full[2*NUM_W-1:NUM_W];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        mag_d   = q_fix;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = (q_fix == '0) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (load) begin
          ov_d = 1'b1;
          ob_d = 1'b0;
          if (bad_q) begin
            oc_d    = CHAR_NUL;
            ol_d    = 1'b1;
            ob_d    = 1'b1;
            state_d = ST_IDLE;
          end else if (neg_q) begin
            oc_d  = CHAR_MINUS;
            ol_d  = 1'b0;
            neg_d = 1'b0;
          end else begin
            oc_d  = stack_q[rd_idx];
            ol_d  = (cnt_q == CNT_W'(1));
            cnt_d = cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    prod_q <= prod_d;
    base_q <= base_d;
    neg_q  <= neg_d;
    bad_q  <= bad_d;
    cnt_q  <= cnt_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    ob_q   <= ob_d;
    if (state_q == ST_FIX) begin
      stack_q[cnt_q[IDX_W-1:0]] <= digit_char(r_fix[RADIX_W-1:0]);
    end
  end

endmodule

// ----- sv/itrt_checker.sv -----
module itrt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i,
  input logic       out_bad_i
);
  import itrt_pkg::*;

  logic ch_digit, ch_alpha;

  assign ch_digit = (out_char_i >= 8'h30) && (out_char_i <= 8'h39);
  assign ch_alpha = (out_char_i >= 8'h61) && (out_char_i <= 8'h7A);

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_char_i) && $stable(out_last_i) && $stable(out_bad_i))
    else $error("output payload changed while stalled");

  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_i |-> out_last_i && (out_char_i == CHAR_NUL))
    else $error("bad base transfer not a lone nul");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_bad_i |->
      ch_digit || ch_alpha || (out_char_i == CHAR_MINUS && !out_last_i))
    else $error("character outside digit set");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.last),
  .out_bad_i   (out_o.bad_radix)
);
